[rtl/core/renc_pkg.sv]
// Shared types and constants for the rotary encoder interface.
package renc_pkg;

  // One encoder sample.
  typedef struct packed {
    logic        phase_a;
    logic        phase_b;
    logic        switch_level;
    logic [31:0] time_ms;
  } sample_t;

  // One decoded result.
  typedef struct packed {
    logic signed [31:0] position_count;
    logic [1:0]         step_event;
    logic               button_stable;
    logic [1:0]         button_event;
  } result_t;

  // Rotary status for the current transaction.
  typedef struct packed {
    logic signed [31:0] position_count;
    logic [1:0]         step_event;
  } quad_status_t;

  // Switch status for the current transaction.
  typedef struct packed {
    logic       button_stable;
    logic [1:0] button_event;
  } button_status_t;

  localparam logic [1:0] STEP_NONE = 2'd0;
  localparam logic [1:0] STEP_UP   = 2'd1;
  localparam logic [1:0] STEP_DOWN = 2'd2;

  localparam logic [1:0] BTN_NONE     = 2'd0;
  localparam logic [1:0] BTN_PRESSED  = 2'd1;
  localparam logic [1:0] BTN_RELEASED = 2'd2;

  localparam logic [1:0]  PHASE_IDLE        = 2'b11;
  localparam logic [15:0] DEBOUNCE_RESET_MS = 16'd40;

  // Quadrature transition table, indexed by {old pair, new pair}.
  localparam logic signed [1:0] QUAD_TABLE [16] = '{
    2'sd0,  -2'sd1, 2'sd1,  2'sd0,
    2'sd1,  2'sd0,  2'sd0,  -2'sd1,
    -2'sd1, 2'sd0,  2'sd0,  2'sd1,
    2'sd0,  2'sd1,  -2'sd1, 2'sd0
  };

endpackage

[rtl/core/renc_quad.sv]
// Quadrature decoder with detent accumulator and position counter.
module renc_quad
  import renc_pkg::*;
#(
  parameter int POSITION_WIDTH   = 32,
  parameter int STEPS_PER_DETENT = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         update,
  input  logic         phase_a,
  input  logic         phase_b,
  output quad_status_t status
);

  localparam logic signed [3:0] STEPS = 4'(STEPS_PER_DETENT);

  logic [1:0]                last_phase;
  logic [1:0]                last_phase_next;
  logic signed [3:0]         acc;
  logic signed [3:0]         acc_next;
  logic signed [3:0]         acc_sum;
  logic [POSITION_WIDTH-1:0] position;
  logic [POSITION_WIDTH-1:0] position_next;
  logic [1:0]                phase;
  logic [1:0]                step_event;

  assign phase = {phase_a, phase_b};

  always_comb begin
    last_phase_next = last_phase;
    acc_next        = acc;
    position_next   = position;
    step_event      = STEP_NONE;
    acc_sum         = acc + 4'(QUAD_TABLE[{last_phase, phase}]);
    if (phase != last_phase) begin
      last_phase_next = phase;
      acc_next        = acc_sum;
      if (acc_sum >= STEPS) begin
        position_next = position + POSITION_WIDTH'(1);
        step_event    = STEP_UP;
        acc_next      = '0;
      end else if (acc_sum <= -STEPS) begin
        position_next = position - POSITION_WIDTH'(1);
        step_event    = STEP_DOWN;
        acc_next      = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_phase <= PHASE_IDLE;
      acc        <= '0;
      position   <= '0;
    end else if (update) begin
      last_phase <= last_phase_next;
      acc        <= acc_next;
      position   <= position_next;
    end
  end

  // Sign-extend or truncate the position to the 32-bit result field.
  generate
    if (POSITION_WIDTH >= 32) begin : g_trunc
      assign status.position_count = $signed(position_next[31:0]);
    end else begin : g_extend
      assign status.position_count =
        $signed({{(32-POSITION_WIDTH){position_next[POSITION_WIDTH-1]}}, position_next});
    end
  endgenerate

  assign status.step_event = step_event;

`ifndef SYNTH
  a_acc_range: assert property (@(posedge clk) disable iff (rst)
    (acc < STEPS) && (acc > -STEPS))
    else $error("detent accumulator out of range");
`endif

endmodule

[rtl/core/renc_debounce.sv]
// Push switch debouncer with programmable hold time.
module renc_debounce
  import renc_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           update,
  input  logic           cfg_write,
  input  logic [15:0]    cfg_data,
  input  logic           switch_level,
  input  logic [31:0]    time_ms,
  output button_status_t status
);

  logic [15:0] debounce_time;
  logic        raw;
  logic        raw_next;
  logic        stable;
  logic        stable_next;
  logic [31:0] stamp;
  logic [31:0] stamp_next;
  logic [31:0] elapsed;
  logic [1:0]  button_event;

  always_comb begin
    raw_next     = raw;
    stamp_next   = stamp;
    stable_next  = stable;
    button_event = BTN_NONE;
    if (switch_level != raw) begin
      raw_next   = switch_level;
      stamp_next = time_ms;
    end
    // Elapsed time wraps with the timestamp.
    elapsed = time_ms - stamp_next;
    if ((raw_next != stable) && (elapsed >= {16'd0, debounce_time})) begin
      stable_next  = raw_next;
      button_event = raw_next ? BTN_RELEASED : BTN_PRESSED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_time <= DEBOUNCE_RESET_MS;
    end else if (cfg_write) begin
      debounce_time <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raw    <= 1'b1;
      stable <= 1'b1;
      stamp  <= '0;
    end else if (update) begin
      raw    <= raw_next;
      stable <= stable_next;
      stamp  <= stamp_next;
    end
  end

  assign status.button_stable = stable_next;
  assign status.button_event  = button_event;

endmodule

[rtl/core/rotary_encoder_interface.sv]
// Top level of the rotary encoder interface: sample register, decode, result register.
//
// Usage: each sample transaction carries the two phase lines, the raw push
// switch level and a millisecond timestamp. Every accepted sample yields
// exactly one result transaction with the detent position, a step event,
// the debounced switch level and a button event.
// Channels: sample (sample_valid/sample_stall), result (result_valid/
// result_stall), and a write-only cfg channel (cfg_valid/cfg_ready) that
// loads the 16-bit debounce time; cfg_ready is always high.
// Latency: an accepted sample is held in the sample register, decoded
// combinationally and registered into the result register. Throughput:
// one sample per cycle while the result is not stalled, set by the single
// decode step between the sample register and the result register.
// Reset (rst, synchronous): phases idle high, position and accumulator
// zero, switch released, debounce time 40 ms, both channels empty.
// Stall: while result_stall holds a waiting result, the sample register
// still takes one more transaction; sample_stall rises once both are full.
module rotary_encoder_interface
  import renc_pkg::*;
#(
  parameter int POSITION_WIDTH   = 32,
  parameter int STEPS_PER_DETENT = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        sample_valid,
  output logic        sample_stall,
  input  sample_t     sample,
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic           s1_valid;
  sample_t        s1;
  logic           advance;
  logic           move;
  logic           accept;
  quad_status_t   quad_status;
  button_status_t button_status;

  assign advance      = !result_valid || !result_stall;
  assign move         = s1_valid && advance;
  assign sample_stall = s1_valid && !advance;
  assign accept       = sample_valid && !sample_stall;
  assign cfg_ready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= sample;
    end
  end

  renc_quad #(
    .POSITION_WIDTH   (POSITION_WIDTH),
    .STEPS_PER_DETENT (STEPS_PER_DETENT)
  ) u_quad (
    .clk     (clk),
    .rst     (rst),
    .update  (move),
    .phase_a (s1.phase_a),
    .phase_b (s1.phase_b),
    .status  (quad_status)
  );

  renc_debounce u_debounce (
    .clk          (clk),
    .rst          (rst),
    .update       (move),
    .cfg_write    (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .switch_level (s1.switch_level),
    .time_ms      (s1.time_ms),
    .status       (button_status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      result.position_count <= quad_status.position_count;
      result.step_event     <= quad_status.step_event;
      result.button_stable  <= button_status.button_stable;
      result.button_event   <= button_status.button_event;
    end
  end

`ifndef SYNTH
  a_hold_sample: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1))
    else $error("pending sample lost while result stalled");

  a_step_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.step_event != 2'd3) && (result.button_event != 2'd3))
    else $error("illegal event code on result");

  a_press_level: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.button_event == BTN_PRESSED) |-> !result.button_stable)
    else $error("press event with released level");

  a_release_level: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.button_event == BTN_RELEASED) |-> result.button_stable)
    else $error("release event with pressed level");
`endif

endmodule

[tb/testbench.sv]
// Self-checking testbench for the rotary encoder interface: quadrature decode and debounce.
`timescale 1ns / 1ps

module testbench;
  import renc_pkg::*;

  localparam int DETENT_STEPS   = 4;
  localparam int MAX_WAIT       = 14;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 4;
  localparam int PHASE_ITEMS    = 75;

  typedef enum bit {ROW_SAMPLE, ROW_CONFIG} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    sample_t     smp;
    logic [15:0] dbnc;
    bit          typed;
    result_t     want;
  } plan_row_t;

  logic        clk;
  logic        rst        = 1'b1;
  logic        smp_valid  = 1'b0;
  logic        smp_stall;
  sample_t     smp_in     = '0;
  logic        res_valid;
  logic        res_stall  = 1'b0;
  result_t     res_out;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data   = '0;

  // Decoder state mirrored by the testbench.
  logic [1:0]  quad_last;
  int          detent_acc;
  logic [31:0] detent_pos;
  logic        sw_raw;
  logic        sw_stable;
  logic [31:0] sw_stamp;
  logic [15:0] hold_limit;

  int quad_delta [16] = '{0, -1, 1, 0, 1, 0, 0, -1, -1, 0, 0, 1, 0, 1, -1, 0};

  result_t   pending_decodes [$];
  plan_row_t plan_rows [$];

  int mismatch_count = 0;
  int quiet_cycles   = 0;
  int stall_left     = 0;
  bit steady_tx      = 1'b0;
  bit steady_rx      = 1'b0;

  rotary_encoder_interface u_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (smp_valid),
    .sample_stall (smp_stall),
    .sample       (smp_in),
    .result_valid (res_valid),
    .result_stall (res_stall),
    .result       (res_out),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic result_t decode_sample(input sample_t s);
    result_t     r;
    logic [1:0]  pair;
    logic [31:0] held;
    r              = '0;
    r.step_event   = STEP_NONE;
    r.button_event = BTN_NONE;
    pair           = {s.phase_a, s.phase_b};
    if (pair != quad_last) begin
      detent_acc += quad_delta[{quad_last, pair}];
      quad_last  = pair;
      if (detent_acc >= DETENT_STEPS || detent_acc <= -DETENT_STEPS) begin
        if (detent_acc > 0) begin
          detent_pos   = detent_pos + 32'd1;
          r.step_event = STEP_UP;
        end else begin
          detent_pos   = detent_pos - 32'd1;
          r.step_event = STEP_DOWN;
        end
        detent_acc = 0;
      end
    end
    if (s.switch_level != sw_raw) begin
      sw_raw   = s.switch_level;
      sw_stamp = s.time_ms;
    end
    // elapsed time wraps modulo 2^32
    held = s.time_ms - sw_stamp;
    if (sw_raw != sw_stable && held >= {16'd0, hold_limit}) begin
      sw_stable      = sw_raw;
      r.button_event = sw_stable ? BTN_RELEASED : BTN_PRESSED;
    end
    r.position_count = detent_pos;
    r.button_stable  = sw_stable;
    return r;
  endfunction

  task automatic add_sample(input sample_t s, input bit typed, input result_t want);
    plan_row_t r;
    r.kind  = ROW_SAMPLE;
    r.smp   = s;
    r.dbnc  = '0;
    r.typed = typed;
    r.want  = want;
    plan_rows.push_back(r);
  endtask

  task automatic add_config(input logic [15:0] v);
    plan_row_t r;
    r.kind  = ROW_CONFIG;
    r.smp   = '0;
    r.dbnc  = v;
    r.typed = 1'b0;
    r.want  = '0;
    plan_rows.push_back(r);
  endtask

  task automatic send_sample(input sample_t s, input bit typed, input result_t want);
    int      gap;
    result_t got;
    gap = steady_tx ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap != 0) begin
      smp_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    smp_in    <= s;
    smp_valid <= 1'b1;
    do @(posedge clk); while (!(smp_valid && !smp_stall));
    got = decode_sample(s);
    pending_decodes.push_back(typed ? want : got);
  endtask

  // Drain all outstanding results, then load a new debounce time.
  task automatic write_debounce(input logic [15:0] v);
    smp_valid <= 1'b0;
    while (pending_decodes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    hold_limit = v;
    cfg_valid <= 1'b0;
  endtask

  // Result side: check each transaction and draw the next stall.
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (pending_decodes.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected result transaction: pos %0d step %0d stable %0b button %0d",
                   res_out.position_count, res_out.step_event, res_out.button_stable,
                   res_out.button_event);
        mismatch_count++;
      end else begin
        if (res_out.position_count !== pending_decodes[0].position_count ||
            res_out.step_event     !== pending_decodes[0].step_event ||
            res_out.button_stable  !== pending_decodes[0].button_stable ||
            res_out.button_event   !== pending_decodes[0].button_event) begin
          if (mismatch_count < 10)
            $display("result mismatch: expected pos %0d step %0d stable %0b button %0d, %s",
                     pending_decodes[0].position_count, pending_decodes[0].step_event,
                     pending_decodes[0].button_stable, pending_decodes[0].button_event,
                     $sformatf("got pos %0d step %0d stable %0b button %0d",
                               res_out.position_count, res_out.step_event,
                               res_out.button_stable, res_out.button_event));
          mismatch_count++;
        end
        void'(pending_decodes.pop_front());
      end
      stall_left = steady_rx ? 0 : $urandom_range(0, MAX_WAIT);
    end else if (stall_left > 0) begin
      stall_left--;
    end
    res_stall <= (stall_left != 0);
  end

  always @(posedge clk) begin
    if (rst || (smp_valid && !smp_stall) || (res_valid && !res_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    logic [1:0]  gray_up [4];
    logic [15:0] dbnc_plan [6];
    logic [31:0] now_ms;
    logic        sw_level;
    int          walk_idx;
    bit          walk_up;
    int          ph;
    int          n;
    int          k;
    int          pick;
    sample_t     s;

    gray_up     = '{2'b11, 2'b01, 2'b00, 2'b10};
    quad_last   = PHASE_IDLE;
    detent_acc  = 0;
    detent_pos  = '0;
    sw_raw      = 1'b1;
    sw_stable   = 1'b1;
    sw_stamp    = '0;
    hold_limit  = DEBOUNCE_RESET_MS;

    // idle sample right after reset
    add_sample(sample_t'{1'b1, 1'b1, 1'b1, 32'd0}, 1'b1,
               result_t'{32'sd0, STEP_NONE, 1'b1, BTN_NONE});
    // one detent up
    add_sample(sample_t'{1'b0, 1'b1, 1'b1, 32'd1}, 1'b0, '0);
    add_sample(sample_t'{1'b0, 1'b0, 1'b1, 32'd2}, 1'b0, '0);
    add_sample(sample_t'{1'b1, 1'b0, 1'b1, 32'd3}, 1'b0, '0);
    add_sample(sample_t'{1'b1, 1'b1, 1'b1, 32'd4}, 1'b1,
               result_t'{32'sd1, STEP_UP, 1'b1, BTN_NONE});
    // two detents down, the second wraps below zero
    for (k = 0; k < 2; k++) begin
      add_sample(sample_t'{1'b1, 1'b0, 1'b1, 32'd5 + 4 * k}, 1'b0, '0);
      add_sample(sample_t'{1'b0, 1'b0, 1'b1, 32'd6 + 4 * k}, 1'b0, '0);
      add_sample(sample_t'{1'b0, 1'b1, 1'b1, 32'd7 + 4 * k}, 1'b0, '0);
    end
    plan_rows.insert(8, '{ROW_SAMPLE, sample_t'{1'b1, 1'b1, 1'b1, 32'd8}, '0, 1'b1,
                          result_t'{32'sd0, STEP_DOWN, 1'b1, BTN_NONE}});
    add_sample(sample_t'{1'b1, 1'b1, 1'b1, 32'd12}, 1'b1,
               result_t'{-32'sd1, STEP_DOWN, 1'b1, BTN_NONE});
    // jumps across both bits count nothing
    add_sample(sample_t'{1'b0, 1'b0, 1'b1, 32'd13}, 1'b0, '0);
    add_sample(sample_t'{1'b1, 1'b1, 1'b1, 32'd14}, 1'b1,
               result_t'{-32'sd1, STEP_NONE, 1'b1, BTN_NONE});
    // press, held one short of the debounce time, then exactly
    add_sample(sample_t'{1'b1, 1'b1, 1'b0, 32'd100}, 1'b0, '0);
    add_sample(sample_t'{1'b1, 1'b1, 1'b0, 32'd139}, 1'b1,
               result_t'{-32'sd1, STEP_NONE, 1'b1, BTN_NONE});
    add_sample(sample_t'{1'b1, 1'b1, 1'b0, 32'd140}, 1'b1,
               result_t'{-32'sd1, STEP_NONE, 1'b0, BTN_PRESSED});
    // release across the timestamp wrap
    add_sample(sample_t'{1'b1, 1'b1, 1'b1, 32'hFFFF_FFF0}, 1'b0, '0);
    add_sample(sample_t'{1'b1, 1'b1, 1'b1, 32'h0000_0017}, 1'b1,
               result_t'{-32'sd1, STEP_NONE, 1'b0, BTN_NONE});
    add_sample(sample_t'{1'b1, 1'b1, 1'b1, 32'h0000_0018}, 1'b1,
               result_t'{-32'sd1, STEP_NONE, 1'b1, BTN_RELEASED});
    // zero debounce follows the raw level at once
    add_config(16'd0);
    add_sample(sample_t'{1'b1, 1'b1, 1'b0, 32'h0000_0018}, 1'b1,
               result_t'{-32'sd1, STEP_NONE, 1'b0, BTN_PRESSED});
    // longest debounce time
    add_config(16'hFFFF);
    add_sample(sample_t'{1'b1, 1'b1, 1'b1, 32'd5}, 1'b1,
               result_t'{-32'sd1, STEP_NONE, 1'b0, BTN_NONE});
    add_sample(sample_t'{1'b1, 1'b1, 1'b1, 32'd65539}, 1'b1,
               result_t'{-32'sd1, STEP_NONE, 1'b0, BTN_NONE});
    add_sample(sample_t'{1'b1, 1'b1, 1'b1, 32'd65540}, 1'b1,
               result_t'{-32'sd1, STEP_NONE, 1'b1, BTN_RELEASED});

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (plan_rows[i]) begin
      case (plan_rows[i].kind)
        ROW_CONFIG: begin
          write_debounce(plan_rows[i].dbnc);
        end
        default: begin
          send_sample(plan_rows[i].smp, plan_rows[i].typed, plan_rows[i].want);
        end
      endcase
    end

    // Random part: quadrature walks with reversals, holds and broken jumps,
    // plus a bouncing switch whose timing clusters around the threshold.
    dbnc_plan = '{16'd0, 16'hFFFF, 16'd1, 16'($urandom_range(2, 300)), DEBOUNCE_RESET_MS,
                  16'd7};
    walk_idx = 0;
    for (k = 0; k < 4; k++)
      if (gray_up[k] == quad_last) walk_idx = k;
    walk_up  = 1'b1;
    sw_level = sw_raw;
    now_ms   = 32'd70000;
    for (ph = 0; ph < 6; ph++) begin
      write_debounce(dbnc_plan[ph]);
      if (ph == 1 || ph == 4) now_ms = 32'hFFFF_FFFF - $urandom_range(0, 400);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 25 == 0) begin
          steady_tx = ($urandom_range(0, 2) == 0);
          steady_rx = ($urandom_range(0, 2) == 0);
        end
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          walk_idx = (walk_idx + (walk_up ? 1 : 3)) % 4;
        end else if (pick < 80) begin
          walk_up  = ~walk_up;
          walk_idx = (walk_idx + (walk_up ? 1 : 3)) % 4;
        end else if (pick < 95) begin
          if (pick >= 90) walk_idx = (walk_idx + 2) % 4;
        end else begin
          walk_idx = $urandom_range(0, 3);
        end
        if ($urandom_range(0, 5) == 0) sw_level = ~sw_level;
        pick = $urandom_range(0, 99);
        if (pick < 80)
          now_ms = now_ms + $urandom_range(0, hold_limit / 4 + 2);
        else if (pick < 93)
          now_ms = sw_stamp + hold_limit + $urandom_range(0, 2) - 1;
        else
          now_ms = $urandom;
        s.phase_a      = gray_up[walk_idx][1];
        s.phase_b      = gray_up[walk_idx][0];
        s.switch_level = sw_level;
        s.time_ms      = now_ms;
        send_sample(s, 1'b0, '0);
      end
    end

    smp_valid <= 1'b0;
    while (pending_decodes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
